FILE: rtl/ibbc_pkg.sv
// Shared types and codes for the indexed bounding box center block.
`default_nettype none

package ibbc_pkg;

	localparam int OP_W    = 2;
	localparam int IDX_W   = 16;
	localparam int COORD_W = 32;
	localparam int STAT_W  = 2;
	localparam int LEN_W   = 33;
	localparam int CNT_W   = 13;

	typedef logic [OP_W-1:0]           op_t;
	typedef logic signed [IDX_W-1:0]   idx_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [STAT_W-1:0]         stat_t;
	typedef logic [LEN_W-1:0]          len_t;
	typedef logic [CNT_W-1:0]          cnt_t;

	localparam op_t OP_WRITE  = 2'd0;
	localparam op_t OP_INDEX  = 2'd1;
	localparam op_t OP_FINISH = 2'd2;

	localparam stat_t STAT_OK     = 2'd0;
	localparam stat_t STAT_EMPTY  = 2'd1;
	localparam stat_t STAT_BOUNDS = 2'd2;
	localparam stat_t STAT_DEGEN  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SQUARE,
		ST_ADD,
		ST_ROOT,
		ST_LOAD
	} state_t;

	// control strobes decoded from the sequencer state
	typedef struct packed {
		logic in_rdy;
		logic upd_en;
		logic mul_en;
		logic add_en;
		logic root_en;
		logic load_en;
	} ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/ibbc_if.sv
// Channel interfaces: input items, result items and the configuration write.
`default_nettype none

interface ibbc_item_if;
	logic            valid;
	logic            ready;
	ibbc_pkg::op_t    operation;
	ibbc_pkg::idx_t   vertex_index;
	ibbc_pkg::coord_t coord_x;
	ibbc_pkg::coord_t coord_y;
	ibbc_pkg::coord_t coord_z;

	modport source (output valid, operation, vertex_index, coord_x, coord_y, coord_z,
		input ready);
	modport sink (input valid, operation, vertex_index, coord_x, coord_y, coord_z,
		output ready);
endinterface

interface ibbc_result_if;
	logic             valid;
	logic             ready;
	ibbc_pkg::stat_t  status;
	ibbc_pkg::coord_t box_min_x;
	ibbc_pkg::coord_t box_min_y;
	ibbc_pkg::coord_t box_min_z;
	ibbc_pkg::coord_t box_max_x;
	ibbc_pkg::coord_t box_max_y;
	ibbc_pkg::coord_t box_max_z;
	ibbc_pkg::coord_t center_x;
	ibbc_pkg::coord_t center_y;
	ibbc_pkg::coord_t center_z;
	ibbc_pkg::len_t   extent_length;

	modport source (output valid, status, box_min_x, box_min_y, box_min_z,
		box_max_x, box_max_y, box_max_z, center_x, center_y, center_z,
		extent_length, input ready);
	modport sink (input valid, status, box_min_x, box_min_y, box_min_z,
		box_max_x, box_max_y, box_max_z, center_x, center_y, center_z,
		extent_length, output ready);
endinterface

interface ibbc_cfg_if;
	logic           valid;
	logic           ready;
	ibbc_pkg::cnt_t vtx_limit;

	modport source (output valid, vtx_limit, input ready);
	modport sink (input valid, vtx_limit, output ready);
endinterface

`default_nettype wire

FILE: rtl/ibbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ibbc_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/indexed_bounding_box_center_core.sv
// Top level: indexed 3D bounding box with center and diagonal length.
//
//   channel   dir  handshake      carries
//   items     in   valid/ready    operation, vertex_index, coord_x/y/z
//   results   out  valid/ready    status, box min/max, center, extent_length
//   cfg       in   valid/ready    vtx_limit, the vertex limit (always ready)
//
// Steps: a vertex write goes straight into the vertex RAM; an index item reads
// the vertex RAM, then updates min/max. A finish item makes three multiply/add
// passes through the one shared multiplier, then COORD_BITS+1 steps of the
// bit-serial square root; an empty or faulted box goes straight to loading.
// Loading the result waits until the output register is free.
// Reset clears the accumulators, the vertex limit and the sequencer; the vertex
// RAM holds garbage until written. Items are not taken while the sequencer
// is busy; a pending result does not block writes or index items.
`default_nettype none

module indexed_bounding_box_center_core #(
	parameter int MAX_VERTICES = 4096,
	parameter int COORD_BITS   = 32
) (
	input wire logic            clk,
	input wire logic            arst_n,
	ibbc_item_if.sink           items,
	ibbc_result_if.source       results,
	ibbc_cfg_if.sink            cfg
);

	localparam int CB    = COORD_BITS;
	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int PW    = 2 * CB;         // one square
	localparam int SW    = 2 * CB + 2;     // sum of three squares, radicand
	localparam int RW    = CB + 1;         // root bits
	localparam int REM_W = CB + 2;
	localparam int RC_W  = $clog2(CB + 1);
	localparam int IW    = ibbc_pkg::IDX_W;

	localparam logic [IW-1:0]       MAX_V   = IW'(MAX_VERTICES);
	localparam logic signed [CB-1:0] LO_INIT = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] HI_INIT = {1'b1, {(CB-1){1'b0}}};

	ibbc_pkg::state_t state_q, state_d;
	ibbc_pkg::ctrl_t  ctrl;

	ibbc_pkg::cnt_t vtx_limit_q;

	// accumulators
	logic signed [CB-1:0] lo_q [3];
	logic signed [CB-1:0] hi_q [3];
	logic                 fault_q;
	logic                 seen_q;
	logic                 hit_q;
	ibbc_pkg::stat_t      stat_q;

	// shared arithmetic
	logic [1:0]       ax_q;
	logic [PW-1:0]    prod_q;
	logic [SW-1:0]    sum_q;
	logic [REM_W-1:0] rem_q;
	logic [RW-1:0]    root_q;
	logic [RC_W-1:0]  step_q;

	// result register
	logic                  res_valid_q;
	ibbc_pkg::stat_t       res_stat_q;
	ibbc_pkg::coord_t      res_min_q [3];
	ibbc_pkg::coord_t      res_max_q [3];
	ibbc_pkg::coord_t      res_ctr_q [3];
	ibbc_pkg::len_t        res_len_q;

	logic              in_acc;
	logic [IW-1:0]     idx_u;
	logic              idx_in_store;
	logic              idx_in_count;
	logic [3*CB-1:0]   wr_data;
	logic [3*CB-1:0]   rd_data;
	logic              out_free;
	logic              root_last;
	logic              degen;

	logic signed [CB-1:0] lo_sel, hi_sel;
	logic signed [CB:0]   diff;
	logic [CB:0]          mag;
	logic [CB-1:0]        dlen;

	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;

	logic signed [CB:0]   mid_sum [3];
	ibbc_pkg::coord_t     ctr_w [3];

	assign in_acc   = items.valid && ctrl.in_rdy;
	assign out_free = !res_valid_q || results.ready;

	// store address: nonnegative and below MAX_VERTICES
	assign idx_u        = items.vertex_index;
	assign idx_in_store = !idx_u[IW-1] && (idx_u < MAX_V);
	assign idx_in_count = idx_u < {{(IW-ibbc_pkg::CNT_W){1'b0}}, vtx_limit_q};

	assign wr_data = {items.coord_z[CB-1:0], items.coord_y[CB-1:0], items.coord_x[CB-1:0]};

	ibbc_ram #(
		.WIDTH (3 * CB),
		.DEPTH (MAX_VERTICES)
	) u_vram (
		.clk   (clk),
		.we    (in_acc && items.operation == ibbc_pkg::OP_WRITE && idx_in_store),
		.waddr (idx_u[AW-1:0]),
		.wdata (wr_data),
		.re    (in_acc && items.operation == ibbc_pkg::OP_INDEX),
		.raddr (idx_u[AW-1:0]),
		.rdata (rd_data)
	);

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ibbc_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (items.operation)
						ibbc_pkg::OP_INDEX: state_d = ibbc_pkg::ST_READ;
						ibbc_pkg::OP_FINISH: begin
							if (!seen_q || fault_q) begin
								state_d = ibbc_pkg::ST_LOAD;
							end else begin
								state_d = ibbc_pkg::ST_SQUARE;
							end
						end
						default: state_d = ibbc_pkg::ST_IDLE;
					endcase
				end
			end
			ibbc_pkg::ST_READ:   state_d = ibbc_pkg::ST_IDLE;
			ibbc_pkg::ST_SQUARE: state_d = ibbc_pkg::ST_ADD;
			ibbc_pkg::ST_ADD: begin
				state_d = (ax_q == 2'd2) ? ibbc_pkg::ST_ROOT : ibbc_pkg::ST_SQUARE;
			end
			ibbc_pkg::ST_ROOT: begin
				if (root_last) begin
					state_d = ibbc_pkg::ST_LOAD;
				end
			end
			ibbc_pkg::ST_LOAD: begin
				if (out_free) begin
					state_d = ibbc_pkg::ST_IDLE;
				end
			end
			default: state_d = ibbc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ibbc_pkg::ST_IDLE:   ctrl.in_rdy  = 1'b1;
			ibbc_pkg::ST_READ:   ctrl.upd_en  = hit_q;
			ibbc_pkg::ST_SQUARE: ctrl.mul_en  = 1'b1;
			ibbc_pkg::ST_ADD:    ctrl.add_en  = 1'b1;
			ibbc_pkg::ST_ROOT:   ctrl.root_en = 1'b1;
			ibbc_pkg::ST_LOAD:   ctrl.load_en = out_free;
			default:             ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ibbc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_limit_q <= '0;
		end else if (cfg.valid) begin
			vtx_limit_q <= cfg.vtx_limit;
		end
	end

	// ---------------- accumulators ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				lo_q[a] <= LO_INIT;
				hi_q[a] <= HI_INIT;
			end
			fault_q <= 1'b0;
			seen_q  <= 1'b0;
			hit_q   <= 1'b0;
			stat_q  <= ibbc_pkg::STAT_OK;
		end else begin
			if (in_acc && items.operation == ibbc_pkg::OP_INDEX) begin
				seen_q <= 1'b1;
				hit_q  <= idx_in_store && idx_in_count;
				if (!(idx_in_store && idx_in_count)) begin
					fault_q <= 1'b1;
				end
			end
			if (in_acc && items.operation == ibbc_pkg::OP_FINISH) begin
				if (!seen_q) begin
					stat_q <= ibbc_pkg::STAT_EMPTY;
				end else if (fault_q) begin
					stat_q <= ibbc_pkg::STAT_BOUNDS;
				end else begin
					stat_q <= ibbc_pkg::STAT_OK;
				end
			end
			if (ctrl.upd_en) begin
				for (int a = 0; a < 3; a++) begin
					if ($signed(rd_data[a*CB +: CB]) < lo_q[a]) begin
						lo_q[a] <= $signed(rd_data[a*CB +: CB]);
					end
					if ($signed(rd_data[a*CB +: CB]) > hi_q[a]) begin
						hi_q[a] <= $signed(rd_data[a*CB +: CB]);
					end
				end
			end
			// result taken into the output register: start a fresh box
			if (ctrl.load_en) begin
				for (int a = 0; a < 3; a++) begin
					lo_q[a] <= LO_INIT;
					hi_q[a] <= HI_INIT;
				end
				fault_q <= 1'b0;
				seen_q  <= 1'b0;
			end
		end
	end

	// ---------------- shared multiplier and root step ----------------
	always_comb begin
		case (ax_q)
			2'd0:    begin lo_sel = lo_q[0]; hi_sel = hi_q[0]; end
			2'd1:    begin lo_sel = lo_q[1]; hi_sel = hi_q[1]; end
			2'd2:    begin lo_sel = lo_q[2]; hi_sel = hi_q[2]; end
			default: begin lo_sel = lo_q[0]; hi_sel = hi_q[0]; end
		endcase
	end

	// |hi - lo| always fits CB unsigned bits
	assign diff = (CB+1)'(hi_sel) - (CB+1)'(lo_sel);
	assign mag  = diff[CB] ? (CB+1)'(-diff) : (CB+1)'(diff);
	assign dlen = mag[CB-1:0];

	// one radicand digit pair per step
	assign rem_sh    = {rem_q, sum_q[SW-1 -: 2]};
	assign trial     = {2'b00, root_q[CB-1:0], 2'b01};
	assign root_last = step_q == RC_W'(CB);

	always_ff @(posedge clk) begin
		if (in_acc && items.operation == ibbc_pkg::OP_FINISH) begin
			ax_q   <= 2'd0;
			sum_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			step_q <= '0;
		end
		if (ctrl.mul_en) begin
			prod_q <= {{CB{1'b0}}, dlen} * {{CB{1'b0}}, dlen};
		end
		if (ctrl.add_en) begin
			sum_q <= sum_q + SW'(prod_q);
			ax_q  <= ax_q + 2'd1;
		end
		if (ctrl.root_en) begin
			sum_q  <= sum_q << 2;
			step_q <= step_q + RC_W'(1);
			if (rem_sh >= trial) begin
				rem_q  <= REM_W'(rem_sh - trial);
				root_q <= {root_q[CB-1:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(rem_sh);
				root_q <= {root_q[CB-1:0], 1'b0};
			end
		end
	end

	// ---------------- result register ----------------
	always_comb begin
		degen = 1'b0;
		for (int a = 0; a < 3; a++) begin
			if (lo_q[a] >= hi_q[a]) begin
				degen = 1'b1;
			end
			// floor of (min + max) / 2
			mid_sum[a] = (CB+1)'(lo_q[a]) + (CB+1)'(hi_q[a]);
			ctr_w[a]   = ibbc_pkg::COORD_W'($signed(mid_sum[a][CB:1]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.load_en) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_en) begin
			if (stat_q != ibbc_pkg::STAT_OK) begin
				res_stat_q <= stat_q;
				for (int a = 0; a < 3; a++) begin
					res_min_q[a] <= '0;
					res_max_q[a] <= '0;
					res_ctr_q[a] <= '0;
				end
				res_len_q <= '0;
			end else begin
				res_stat_q <= degen ? ibbc_pkg::STAT_DEGEN : ibbc_pkg::STAT_OK;
				for (int a = 0; a < 3; a++) begin
					res_min_q[a] <= ibbc_pkg::COORD_W'(lo_q[a]);
					res_max_q[a] <= ibbc_pkg::COORD_W'(hi_q[a]);
					res_ctr_q[a] <= ctr_w[a];
				end
				res_len_q <= ibbc_pkg::LEN_W'(root_q);
			end
		end
	end

	assign items.ready           = ctrl.in_rdy;
	assign results.valid         = res_valid_q;
	assign results.status        = res_stat_q;
	assign results.box_min_x     = res_min_q[0];
	assign results.box_min_y     = res_min_q[1];
	assign results.box_min_z     = res_min_q[2];
	assign results.box_max_x     = res_max_q[0];
	assign results.box_max_y     = res_max_q[1];
	assign results.box_max_z     = res_max_q[2];
	assign results.center_x      = res_ctr_q[0];
	assign results.center_y      = res_ctr_q[1];
	assign results.center_z      = res_ctr_q[2];
	assign results.extent_length = res_len_q;

endmodule

`default_nettype wire

FILE: rtl/ibbc_checker.sv
// Port-level checks for the bounding box core, bound to its top level.
`default_nettype none

module ibbc_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire ibbc_pkg::op_t    in_op,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire ibbc_pkg::stat_t  out_status,
	input wire ibbc_pkg::coord_t out_min_x,
	input wire ibbc_pkg::len_t   out_len
);

	// index item needs the RAM read before the next item
	a_index_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op == ibbc_pkg::OP_INDEX |=> !in_ready)
		else $error("index item followed by accept in next cycle");

	// finish item holds off further items while the report is built
	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op == ibbc_pkg::OP_FINISH |=> !in_ready)
		else $error("finish item followed by accept in next cycle");

	// empty or faulted box reports zeros
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status == ibbc_pkg::STAT_EMPTY ||
			out_status == ibbc_pkg::STAT_BOUNDS) |-> out_min_x == '0 && out_len == '0)
		else $error("nonzero fields with empty or out-of-bounds status");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_status))
		else $error("result dropped while stalled");

endmodule

bind indexed_bounding_box_center_core ibbc_checker u_ibbc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (items.valid),
	.in_ready   (items.ready),
	.in_op      (items.operation),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_status (results.status),
	.out_min_x  (results.box_min_x),
	.out_len    (results.extent_length)
);

`default_nettype wire
